FILE: src/met_pkg.sv
// types and constants for the mouse event translator
`default_nettype none

package met_pkg;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_GAIN      = 2'd1;
  localparam logic [1:0] CFG_VERT_OFF  = 2'd2;

  localparam logic [4:0] EV_KEY = 5'h01;
  localparam logic [4:0] EV_REL = 5'h02;

  localparam logic [9:0] REL_X     = 10'h000;
  localparam logic [9:0] REL_Y     = 10'h001;
  localparam logic [9:0] REL_WHEEL = 10'h008;

  localparam logic [9:0] BTN_LEFT   = 10'h110;
  localparam logic [9:0] BTN_RIGHT  = 10'h111;
  localparam logic [9:0] BTN_MIDDLE = 10'h112;
  localparam logic [9:0] BTN_SIDE   = 10'h113;
  localparam logic [9:0] BTN_EXTRA  = 10'h114;

  localparam logic [6:0] MASK_LEFT       = 7'h01;
  localparam logic [6:0] MASK_RIGHT      = 7'h02;
  localparam logic [6:0] MASK_MIDDLE     = 7'h04;
  localparam logic [6:0] MASK_WHEEL_UP   = 7'h08;
  localparam logic [6:0] MASK_WHEEL_DOWN = 7'h10;
  localparam logic [6:0] MASK_SIDE       = 7'h20;
  localparam logic [6:0] MASK_EXTRA      = 7'h40;

  localparam logic [15:0] THRESHOLD_RESET = 16'd10;
  localparam logic [15:0] GAIN_RESET      = 16'd512;

  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic        wheel;
    logic [6:0]  mask;
    logic [6:0]  wheel_sel;
    logic [31:0] x;
    logic [31:0] y;
  } entry_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? INT_MIN : INT_MAX;
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/mouse_event_translator.sv
// mouse event translator top level
//
// input stream: one event per transfer; tuser carries the operation (event,
// flush, clear), tdata the event type, code and signed value. x and y deltas
// accumulate in saturating sums, key events update the button mask.
// output stream: one result per transfer; tdata carries buttons, move_x and
// move_y, tlast marks the final result caused by one input.
// a wheel step gives two results (mask with wheel bit, then plain mask), a
// flush gives at most one accelerated motion result.
// the block takes one input per cycle while tready is high; a wheel entry
// stays at the queue head until both its results are sent. an input passes
// the snapshot register, the multiplier register, then the output queue.
// the queue is FIFO_DEPTH entries; tready drops when the queue plus the
// items still in the two pipeline stages could fill it, so a stalled
// receiver backs up into the input side without losing results.
// configuration writes take effect at once; the user must make them only
// while idle, the block does not enforce it. reset clears the sums, button
// mask, flags, queue and restores register defaults (threshold 10, gain 2.0).
`default_nettype none

module mouse_event_translator
  import met_pkg::*;
#(
  parameter int FIFO_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // event_type, event_code, event_value, zero pad
  input  wire logic [1:0]  s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // buttons, move_x, move_y, zero pad
  output logic             m_axis_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [15:0] accel_threshold;
  logic [15:0] accel_gain_q8;
  logic        vertical_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_threshold <= THRESHOLD_RESET;
      accel_gain_q8   <= GAIN_RESET;
      vertical_off    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD: accel_threshold <= cfg_wdata;
        CFG_GAIN:      accel_gain_q8   <= cfg_wdata;
        CFG_VERT_OFF:  vertical_off    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input decode
  logic [4:0]  in_type;
  logic [9:0]  in_code;
  logic [31:0] in_value;
  op_t         in_op;
  logic        in_xfer;

  assign in_type  = s_axis_tdata[4:0];
  assign in_code  = s_axis_tdata[14:5];
  assign in_value = s_axis_tdata[46:15];
  assign in_op    = op_t'(s_axis_tuser);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // accumulator state
  logic [31:0] sum_x, sum_x_next;
  logic [31:0] sum_y, sum_y_next;
  logic [6:0]  button_mask, button_mask_next;
  logic        mask_changed, mask_changed_next;
  logic        input_seen, input_seen_next;

  // snapshot stage
  logic        s1_valid, s1_valid_next;
  logic        s1_wheel, s1_wheel_next;
  logic [6:0]  s1_wheel_sel, s1_wheel_sel_next;
  logic [6:0]  s1_mask, s1_mask_next;
  logic        s1_changed, s1_changed_next;
  logic [31:0] s1_x, s1_x_next;
  logic [31:0] s1_y, s1_y_next;

  logic [6:0]  key_bit;
  logic        key_hit;

  always_comb begin
    key_hit = 1'b1;
    case (in_code)
      BTN_LEFT:   key_bit = MASK_LEFT;
      BTN_RIGHT:  key_bit = MASK_RIGHT;
      BTN_MIDDLE: key_bit = MASK_MIDDLE;
      BTN_SIDE:   key_bit = MASK_SIDE;
      BTN_EXTRA:  key_bit = MASK_EXTRA;
      default: begin
        key_bit = 7'h00;
        key_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    sum_x_next        = sum_x;
    sum_y_next        = sum_y;
    button_mask_next  = button_mask;
    mask_changed_next = mask_changed;
    input_seen_next   = input_seen;
    s1_valid_next     = 1'b0;
    s1_wheel_next     = 1'b0;
    s1_wheel_sel_next = MASK_WHEEL_UP;
    s1_mask_next      = button_mask;
    s1_changed_next   = mask_changed;
    s1_x_next         = sum_x;
    s1_y_next         = sum_y;
    if (in_xfer) begin
      case (in_op)
        OP_EVENT: begin
          input_seen_next = 1'b1;
          if (in_type == EV_REL) begin
            if (in_code == REL_X) begin
              sum_x_next = sat_add(sum_x, in_value);
            end else if (in_code == REL_Y) begin
              sum_y_next = sat_add(sum_y, in_value);
            end else if (in_code == REL_WHEEL && in_value != 32'd0) begin
              s1_valid_next     = 1'b1;
              s1_wheel_next     = 1'b1;
              s1_wheel_sel_next = in_value[31] ? MASK_WHEEL_DOWN : MASK_WHEEL_UP;
            end
          end else if (in_type == EV_KEY && key_hit) begin
            button_mask_next = (in_value != 32'd0) ? (button_mask | key_bit)
                                                   : (button_mask & ~key_bit);
            if (button_mask_next != button_mask) begin
              mask_changed_next = 1'b1;
            end
          end
        end
        OP_FLUSH: begin
          s1_valid_next     = input_seen;
          sum_x_next        = 32'd0;
          sum_y_next        = 32'd0;
          mask_changed_next = 1'b0;
          input_seen_next   = 1'b0;
        end
        OP_CLEAR: begin
          button_mask_next = 7'h00;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= 32'd0;
      sum_y        <= 32'd0;
      button_mask  <= 7'h00;
      mask_changed <= 1'b0;
      input_seen   <= 1'b0;
      s1_valid     <= 1'b0;
    end else begin
      sum_x        <= sum_x_next;
      sum_y        <= sum_y_next;
      button_mask  <= button_mask_next;
      mask_changed <= mask_changed_next;
      input_seen   <= input_seen_next;
      s1_valid     <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_wheel     <= s1_wheel_next;
    s1_wheel_sel <= s1_wheel_sel_next;
    s1_mask      <= s1_mask_next;
    s1_changed   <= s1_changed_next;
    s1_x         <= s1_x_next;
    s1_y         <= s1_y_next;
  end

  // multiply stage
  logic [31:0] mag_x, mag_y;
  logic [31:0] diff_x, diff_y;

  assign mag_x  = magnitude(s1_x);
  assign mag_y  = magnitude(s1_y);
  assign diff_x = mag_x - {16'd0, accel_threshold};
  assign diff_y = mag_y - {16'd0, accel_threshold};

  logic        s2_valid;
  logic        s2_wheel;
  logic [6:0]  s2_wheel_sel;
  logic [6:0]  s2_mask;
  logic        s2_changed;
  logic [47:0] s2_prod_x, s2_prod_y;
  logic [31:0] s2_mag_x, s2_mag_y;
  logic        s2_gt_x, s2_gt_y;
  logic        s2_neg_x, s2_neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_wheel     <= s1_wheel;
    s2_wheel_sel <= s1_wheel_sel;
    s2_mask      <= s1_mask;
    s2_changed   <= s1_changed;
    s2_prod_x    <= {16'd0, diff_x} * {32'd0, accel_gain_q8};
    s2_prod_y    <= {16'd0, diff_y} * {32'd0, accel_gain_q8};
    s2_mag_x     <= mag_x;
    s2_mag_y     <= mag_y;
    s2_gt_x      <= mag_x > {16'd0, accel_threshold};
    s2_gt_y      <= mag_y > {16'd0, accel_threshold};
    s2_neg_x     <= s1_x[31];
    s2_neg_y     <= s1_y[31];
  end

  // scale, saturate, restore sign, invert or zero y and build the queue entry
  logic [40:0] scaled_x, scaled_y;
  logic [31:0] amag_x, amag_y;
  logic [31:0] out_x, out_y, acc_y;
  logic        push;
  entry_t      push_entry;

  always_comb begin
    scaled_x = {1'b0, s2_prod_x[47:8]} + {25'd0, accel_threshold};
    scaled_y = {1'b0, s2_prod_y[47:8]} + {25'd0, accel_threshold};
    amag_x   = s2_mag_x;
    amag_y   = s2_mag_y;
    if (s2_gt_x) begin
      amag_x = (scaled_x > {9'd0, INT_MAX}) ? INT_MAX : scaled_x[31:0];
    end
    if (s2_gt_y) begin
      amag_y = (scaled_y > {9'd0, INT_MAX}) ? INT_MAX : scaled_y[31:0];
    end
    out_x = s2_neg_x ? (~amag_x + 32'd1) : amag_x;
    acc_y = s2_neg_y ? (~amag_y + 32'd1) : amag_y;
    out_y = vertical_off ? 32'd0 : (~acc_y + 32'd1);

    push_entry.wheel     = s2_wheel;
    push_entry.mask      = s2_mask;
    push_entry.wheel_sel = s2_wheel_sel;
    push_entry.x         = s2_wheel ? 32'd0 : out_x;
    push_entry.y         = s2_wheel ? 32'd0 : out_y;
    push = s2_valid && (s2_wheel || out_x != 32'd0 || out_y != 32'd0 || s2_changed);
  end

  // output queue
  entry_t           fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             second;
  logic             pop;
  logic             out_xfer;
  entry_t           head;

  assign head     = fifo_mem[rd_ptr];
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign pop      = out_xfer && (!head.wheel || second);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      second <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
      if (out_xfer && head.wheel) begin
        second <= !second;
      end
    end
  end

  logic [CNT_W+1:0] committed;
  assign committed = (CNT_W+2)'(count) + (CNT_W+2)'(s1_valid) + (CNT_W+2)'(s2_valid);

  assign s_axis_tready = committed < (CNT_W+2)'(FIFO_DEPTH);
  assign m_axis_tvalid = count != '0;
  assign m_axis_tlast  = !head.wheel || second;
  assign m_axis_tdata  = {1'b0, head.y, head.x,
                          (head.wheel && !second) ? (head.mask | head.wheel_sel)
                                                  : head.mask};

  // checks
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_op == OP_FLUSH |=> sum_x == 32'd0 && sum_y == 32'd0 && !input_seen)
    else $error("flush did not clear accumulators");

  assert property (@(posedge clk) disable iff (rst)
    second |-> m_axis_tvalid && head.wheel)
    else $error("second wheel beat without a wheel entry");

  assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_op == OP_CLEAR |=> button_mask == 7'h00)
    else $error("clear did not reset the button mask");

endmodule

`default_nettype wire
